// File: src/fvn_pkg.sv
// fractal value noise: shared types, constants and the lattice offset function
// no dependencies
`default_nettype none
package fvn_pkg;

  localparam int unsigned COORD_W    = 24;
  localparam int unsigned AMP_W      = 24;
  localparam int unsigned PERSIST_W  = 17;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned TOTAL_W    = 40;
  localparam int unsigned NOISE_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CORNERS    = 4;
  localparam int unsigned GRID       = 16;

  localparam logic [31:0] HASH_MUL_A = 32'd15731;
  localparam logic [31:0] HASH_ADD_A = 32'd789221;
  localparam logic [31:0] HASH_ADD_B = 32'd1376312589;
  localparam logic [31:0] HASH_MASK  = 32'h7fff_ffff;
  localparam logic [31:0] HASH_ONE   = 32'h4000_0000;
  localparam logic [31:0] ROW_STRIDE = 32'd57;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERSISTENCE  = 3'd0,
    REG_OCTAVE_COUNT = 3'd1,
    REG_BASE_FREQ    = 3'd2,
    REG_BASE_AMP     = 3'd3,
    REG_DOUBLE_FREQ  = 3'd4,
    REG_SCALE_AMP    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [PERSIST_W-1:0] persistence;
    logic [COUNT_W-1:0]   octave_count;
    logic [23:0]          base_frequency;
    logic [AMP_W-1:0]     base_amplitude;
    logic                 double_frequency;
    logic                 scale_amplitude;
  } cfg_t;

  // word handed from one octave cell to the next
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [AMP_W-1:0]          amp;
    logic signed [TOTAL_W-1:0] total;
  } chain_t;

  // offset of grid point k (dx,dy in -1..2) from x + 57*y of the sample cell
  function automatic logic [31:0] lattice_offset(input int unsigned k);
    int dx;
    int dy;
    dx = int'(k % 4) - 1;
    dy = int'(k / 4) - 1;
    return 32'(dx + 57 * dy);
  endfunction

endpackage
`default_nettype wire

// File: src/fvn_ifs.sv
// fractal value noise: handshake channels for samples, results and register writes
// depends on fvn_pkg
`default_nettype none
interface fvn_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [fvn_pkg::COORD_W-1:0]       coord_x;
  logic signed [fvn_pkg::COORD_W-1:0]       coord_y;
  modport source (output valid, coord_x, coord_y, input ready);
  modport sink   (input valid, coord_x, coord_y, output ready);
endinterface

interface fvn_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [fvn_pkg::NOISE_W-1:0]       noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

interface fvn_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic [fvn_pkg::CFG_IDX_W-1:0]            index;
  logic [fvn_pkg::CFG_DATA_W-1:0]           data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/fvn_hash.sv
// fractal value noise: four-stage integer lattice hash giving a Q.30 value in (-1,1]
// depends on fvn_pkg
`default_nettype none
module fvn_hash (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [31:0]        n_i,
  output logic signed [31:0]      h_o
);

  logic [31:0] nh_q, nh2_q, nh3_q;
  logic [31:0] sq_q, pp_q;
  logic [31:0] q_w;

  assign q_w = nh3_q * pp_q + fvn_pkg::HASH_ADD_B;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nh_q  <= (n_i << 13) ^ n_i;
      sq_q  <= nh_q * nh_q;
      nh2_q <= nh_q;
      pp_q  <= sq_q * fvn_pkg::HASH_MUL_A + fvn_pkg::HASH_ADD_A;
      nh3_q <= nh2_q;
      h_o   <= $signed(fvn_pkg::HASH_ONE - (q_w & fvn_pkg::HASH_MASK));
    end
  end

endmodule
`default_nettype wire

// File: src/fvn_cell.sv
// fractal value noise: one octave cell, a 14-stage pipeline adding one octave to the word
// depends on fvn_pkg and fvn_hash
`default_nettype none
module fvn_cell #(
  parameter int unsigned MAX_OCTAVES     = 8,
  parameter int unsigned COORD_FRAC_BITS = 8,
  parameter int unsigned OCT             = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire fvn_pkg::cfg_t   cfg_i,
  input  wire logic            valid_i,
  input  wire fvn_pkg::chain_t word_i,
  output logic                 valid_o,
  output fvn_pkg::chain_t      word_o
);

  localparam int unsigned FW     = 24 + MAX_OCTAVES;
  localparam int unsigned MW     = fvn_pkg::COORD_W + FW;
  localparam int unsigned FB     = COORD_FRAC_BITS + 24;
  localparam int unsigned EW     = (MW > FB + 32) ? MW : FB + 32;
  localparam int unsigned STAGES = 14;

  typedef struct packed {
    fvn_pkg::chain_t    w;
    logic signed [17:0] tx;
    logic signed [17:0] ty;
  } pass_t;

  logic [STAGES:1] vld_q;
  pass_t           p_q [1:STAGES-1];

  // stage 1: frequency, coordinate magnitudes, amplitude product
  logic [FW-1:0]      freq_w;
  logic [23:0]        ax_w, ay_w;
  logic [MW-1:0]      magx_q, magy_q;
  logic               negx_q, negy_q;
  logic [40:0]        amp_prod_q;

  always_comb begin
    freq_w = FW'(cfg_i.base_frequency);
    if (cfg_i.double_frequency) begin
      freq_w = freq_w << (OCT + 1);
    end
    ax_w = word_i.cx[23] ? 24'(-word_i.cx) : 24'(word_i.cx);
    ay_w = word_i.cy[23] ? 24'(-word_i.cy) : 24'(word_i.cy);
  end

  // stage 2: lattice index and fraction, new amplitude
  logic [EW-1:0]      magx_e, magy_e;
  logic [31:0]        ipx_w, ipy_w;
  logic [15:0]        frx_w, fry_w;
  logic [25:0]        amp_r_w;
  pass_t              p2_w;
  logic [31:0]        ix_q, iy_q;

  always_comb begin
    magx_e  = EW'(magx_q);
    magy_e  = EW'(magy_q);
    ipx_w   = magx_e[FB +: 32];
    ipy_w   = magy_e[FB +: 32];
    frx_w   = magx_e[FB-16 +: 16];
    fry_w   = magy_e[FB-16 +: 16];
    amp_r_w = 26'((42'(amp_prod_q) + 42'd32768) >> 16);
    p2_w    = p_q[1];
    p2_w.tx = negx_q ? -$signed({2'b00, frx_w}) : $signed({2'b00, frx_w});
    p2_w.ty = negy_q ? -$signed({2'b00, fry_w}) : $signed({2'b00, fry_w});
    if (cfg_i.scale_amplitude) begin
      p2_w.w.amp = (amp_r_w > 26'hff_ffff) ? 24'hff_ffff : amp_r_w[23:0];
    end
  end

  // stage 3: row-major lattice key
  logic [31:0] base_q;

  // stages 4 to 7: sixteen lattice hashes
  logic signed [31:0] h_w [fvn_pkg::GRID];

  for (genvar k = 0; k < fvn_pkg::GRID; k++) begin : g_hash
    fvn_hash u_hash (
      .clk_i (clk_i),
      .en_i  (en_i),
      .n_i   (base_q + fvn_pkg::lattice_offset(k)),
      .h_o   (h_w[k])
    );
  end

  // weights 3u^2-2u^3 for tx, 1-tx, ty, 1-ty: u^2 at stage 6, u^3 at 7, weight at 8
  logic signed [17:0] u5_w [fvn_pkg::CORNERS];
  logic signed [17:0] u6_w [fvn_pkg::CORNERS];
  logic signed [35:0] u2_q [fvn_pkg::CORNERS];
  logic signed [35:0] u2b_q [fvn_pkg::CORNERS];
  logic signed [53:0] u3_q [fvn_pkg::CORNERS];
  logic signed [55:0] wa_w [fvn_pkg::CORNERS];
  logic signed [19:0] w_q  [fvn_pkg::CORNERS];

  always_comb begin
    u5_w[0] = p_q[5].tx;
    u5_w[1] = 18'sd65536 - p_q[5].tx;
    u5_w[2] = p_q[5].ty;
    u5_w[3] = 18'sd65536 - p_q[5].ty;
    u6_w[0] = p_q[6].tx;
    u6_w[1] = 18'sd65536 - p_q[6].tx;
    u6_w[2] = p_q[6].ty;
    u6_w[3] = 18'sd65536 - p_q[6].ty;
    for (int c = 0; c < fvn_pkg::CORNERS; c++) begin
      wa_w[c] = (56'(u2b_q[c]) <<< 17) + (56'(u2b_q[c]) <<< 16)
              - (56'(u3_q[c]) <<< 1) + (56'sd1 <<< 31);
    end
  end

  // stage 8: 3x3 smoothing around the four corners
  logic signed [35:0] s_w [fvn_pkg::CORNERS];
  logic signed [35:0] s_q [fvn_pkg::CORNERS];

  always_comb begin
    for (int c = 0; c < fvn_pkg::CORNERS; c++) begin
      s_w[c] = '0;
      for (int b = 0; b < 3; b++) begin
        for (int a = 0; a < 3; a++) begin
          s_w[c] = s_w[c] + (36'(h_w[((c / 2) + b) * 4 + (c % 2) + a])
                   <<< (((a == 1) ? 1 : 0) + ((b == 1) ? 1 : 0)));
        end
      end
    end
  end

  // stages 9 to 14: bilinear blend, amplitude, accumulate
  logic signed [55:0] m_q [fvn_pkg::CORNERS];
  logic signed [19:0] wy9_q [2];
  logic signed [19:0] wy10_q [2];
  logic signed [41:0] i_q [2];
  logic signed [61:0] mi_q [2];
  logic signed [35:0] v_q;
  logic signed [60:0] va_q;
  logic signed [63:0] i_w [2];
  logic signed [63:0] r_w, v_w, c_w;
  fvn_pkg::chain_t    out_q;
  fvn_pkg::chain_t    out_w;
  logic               active_w;

  always_comb begin
    i_w[0]   = (64'(m_q[0]) + 64'(m_q[1]) + 64'sd32768) >>> 16;
    i_w[1]   = (64'(m_q[2]) + 64'(m_q[3]) + 64'sd32768) >>> 16;
    r_w      = (64'(mi_q[0]) + 64'(mi_q[1]) + 64'sd32768) >>> 16;
    v_w      = (r_w + 64'sd512) >>> 10;
    c_w      = (64'(va_q) + 64'sd8388608) >>> 24;
    active_w = cfg_i.octave_count > 4'(OCT);
    out_w       = p_q[13].w;
    out_w.total = p_q[13].w.total + (active_w ? 40'(c_w) : 40'sd0);
  end

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-1:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[1]     <= '{w: word_i, tx: '0, ty: '0};
      magx_q     <= MW'(ax_w) * MW'(freq_w);
      magy_q     <= MW'(ay_w) * MW'(freq_w);
      negx_q     <= word_i.cx[23];
      negy_q     <= word_i.cy[23];
      amp_prod_q <= 41'(word_i.amp) * 41'(cfg_i.persistence);

      p_q[2]     <= p2_w;
      ix_q       <= negx_q ? 32'd0 - ipx_w : ipx_w;
      iy_q       <= negy_q ? 32'd0 - ipy_w : ipy_w;

      base_q     <= ix_q + iy_q * fvn_pkg::ROW_STRIDE;

      for (int s = 3; s < STAGES; s++) begin
        p_q[s] <= p_q[s-1];
      end

      for (int c = 0; c < fvn_pkg::CORNERS; c++) begin
        u2_q[c]  <= 36'(u5_w[c]) * 36'(u5_w[c]);
        u2b_q[c] <= u2_q[c];
        u3_q[c]  <= 54'(u2_q[c]) * 54'(u6_w[c]);
        w_q[c]   <= wa_w[c][51:32];
        s_q[c]   <= s_w[c];
      end

      // corners 0..3: (x,y), (x+1,y), (x,y+1), (x+1,y+1); weights 0..3: tx, 1-tx, ty, 1-ty
      m_q[0]    <= 56'(s_q[0]) * 56'(w_q[1]);
      m_q[1]    <= 56'(s_q[1]) * 56'(w_q[0]);
      m_q[2]    <= 56'(s_q[2]) * 56'(w_q[1]);
      m_q[3]    <= 56'(s_q[3]) * 56'(w_q[0]);
      wy9_q[0]  <= w_q[2];
      wy9_q[1]  <= w_q[3];

      i_q[0]    <= 42'(i_w[0]);
      i_q[1]    <= 42'(i_w[1]);
      wy10_q    <= wy9_q;

      mi_q[0]   <= 62'(i_q[0]) * 62'(wy10_q[1]);
      mi_q[1]   <= 62'(i_q[1]) * 62'(wy10_q[0]);

      v_q       <= 36'(v_w);

      va_q      <= 61'(v_q) * 61'($signed({1'b0, p_q[12].w.amp}));

      out_q     <= out_w;
    end
  end

  assign valid_o = vld_q[STAGES];
  assign word_o  = out_q;

endmodule
`default_nettype wire

// File: src/fractal_value_noise_2d_unit.sv
// fractal value noise: top level with register file, octave cell chain and output skid
// depends on fvn_pkg, fvn_ifs and fvn_cell
//
//   channel     dir   payload                          moves when
//   sample_i    in    coord_x, coord_y (Q15.8)         valid & ready
//   noise_o     out   noise_value (Q15.16, saturated)  valid & ready
//   cfg_i       in    index (3 bits), data (24 bits)   valid & ready, ready always high
//
// one word accepted per cycle while the skid stage is free; each word passes MAX_OCTAVES
// octave cells of 14 stages, then the output register, before its result appears
// reset clears the valid line, the output and skid flags and loads the register defaults
// a stalled output parks one result in the skid stage; input ready drops only while the
// skid is full, and then the whole cell chain holds
`default_nettype none
module fractal_value_noise_2d_unit #(
  parameter int unsigned MAX_OCTAVES     = 8,
  parameter int unsigned COORD_FRAC_BITS = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fvn_in_if.sink     sample_i,
  fvn_out_if.source  noise_o,
  fvn_cfg_if.sink    cfg_i
);

  // register file
  fvn_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.persistence      <= 17'd16384;
      cfg_q.octave_count     <= 4'd4;
      cfg_q.base_frequency   <= 24'd251658;
      cfg_q.base_amplitude   <= 24'd65536;
      cfg_q.double_frequency <= 1'b0;
      cfg_q.scale_amplitude  <= 1'b0;
    end else if (cfg_i.valid) begin
      case (fvn_pkg::cfg_reg_e'(cfg_i.index))
        fvn_pkg::REG_PERSISTENCE:  cfg_q.persistence      <= cfg_i.data[16:0];
        fvn_pkg::REG_OCTAVE_COUNT: cfg_q.octave_count     <= cfg_i.data[3:0];
        fvn_pkg::REG_BASE_FREQ:    cfg_q.base_frequency   <= cfg_i.data;
        fvn_pkg::REG_BASE_AMP:     cfg_q.base_amplitude   <= cfg_i.data;
        fvn_pkg::REG_DOUBLE_FREQ:  cfg_q.double_frequency <= cfg_i.data[0];
        fvn_pkg::REG_SCALE_AMP:    cfg_q.scale_amplitude  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // chain advances whenever the skid stage is free
  logic en;
  logic out_v_q, skid_v_q;
  logic signed [fvn_pkg::NOISE_W-1:0] out_q, skid_q;

  assign en             = !skid_v_q;
  assign sample_i.ready = en;

  // octave cells
  logic            vld_w  [MAX_OCTAVES+1];
  fvn_pkg::chain_t word_w [MAX_OCTAVES+1];

  assign vld_w[0]        = sample_i.valid;
  assign word_w[0].cx    = sample_i.coord_x;
  assign word_w[0].cy    = sample_i.coord_y;
  assign word_w[0].amp   = cfg_q.base_amplitude;
  assign word_w[0].total = '0;

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
    fvn_cell #(
      .MAX_OCTAVES     (MAX_OCTAVES),
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .OCT             (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .cfg_i   (cfg_q),
      .valid_i (vld_w[g]),
      .word_i  (word_w[g]),
      .valid_o (vld_w[g+1]),
      .word_o  (word_w[g+1])
    );
  end

  // saturate the wide sum to the signed 32-bit range
  logic signed [fvn_pkg::TOTAL_W-1:0] tot_w;
  logic signed [fvn_pkg::NOISE_W-1:0] sat_w;

  always_comb begin
    tot_w = word_w[MAX_OCTAVES].total;
    if (tot_w > 40'sh00_7fff_ffff) begin
      sat_w = 32'sh7fff_ffff;
    end else if (tot_w < -40'sh00_8000_0000) begin
      sat_w = 32'sh8000_0000;
    end else begin
      sat_w = tot_w[31:0];
    end
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en) begin
      if (out_v_q && !noise_o.ready) begin
        skid_v_q <= vld_w[MAX_OCTAVES];
      end else begin
        out_v_q <= vld_w[MAX_OCTAVES];
      end
    end else if (noise_o.ready) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (out_v_q && !noise_o.ready) begin
        skid_q <= sat_w;
      end else begin
        out_q <= sat_w;
      end
    end else if (noise_o.ready) begin
      out_q <= skid_q;
    end
  end

  assign noise_o.valid       = out_v_q;
  assign noise_o.noise_value = out_q;

endmodule
`default_nettype wire
